// File: hdl/tun_pkg.sv
// tun_pkg: widths, payload structs and stage counts for the triangle unit normal block
// no dependencies; imported by every module under hdl
package tun_pkg;

    localparam int COORD_W  = 24;
    localparam int NORMAL_W = 16;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = CROSS_W - 1;
    localparam int POS_W    = $clog2(MAG_W);
    localparam int NORM_TOP = 30;
    localparam int M_W      = NORM_TOP + 1;
    localparam int SQ_W     = 2 * M_W;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int NUM_W    = M_W + NORMAL_W;
    localparam int LAT      = 8 + ROOT_W + 1 + NORMAL_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_in;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] norm_x;
        logic signed [NORMAL_W-1:0] norm_y;
        logic signed [NORMAL_W-1:0] norm_z;
        logic                       degenerate;
    } t_out;

endpackage

// File: hdl/tun_isqrt.sv
// tun_isqrt: pipelined floor square root, one result bit per stage
// depends on tun_pkg
module tun_isqrt import tun_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [ROOT_W:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_rad  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [ROOT_W:0]   s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [SUM_W-1:0]  s_rad;
        logic [ROOT_W+2:0] t_rem;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;

        if (k == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rad  = r_rad[k-1];
        end

        assign t_rem = {s_rem[ROOT_W:0], s_rad[SUM_W-1 -: 2]};
        assign trial = {1'b0, s_root, 2'b01};
        assign diff  = t_rem - trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (t_rem >= trial) begin
                    r_rem[k]  <= diff[ROOT_W:0];
                    r_root[k] <= {s_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= t_rem[ROOT_W:0];
                    r_root[k] <= {s_root[ROOT_W-2:0], 1'b0};
                end
                r_rad[k] <= {s_rad[SUM_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// File: hdl/tun_div.sv
// tun_div: pipelined restoring divider, one quotient bit per stage
// depends on tun_pkg; quotient must fit NORMAL_W bits
module tun_div import tun_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [ROOT_W-1:0]   i_den,
    output logic [NORMAL_W-1:0] o_quo
);

    logic [ROOT_W-1:0]   r_rem [NORMAL_W];
    logic [NORMAL_W-1:0] r_low [NORMAL_W];
    logic [ROOT_W-1:0]   r_den [NORMAL_W];
    logic [NORMAL_W-1:0] r_quo [NORMAL_W];

    for (genvar k = 0; k < NORMAL_W; k++) begin : g_stage
        logic [ROOT_W-1:0]   s_rem;
        logic [NORMAL_W-1:0] s_low;
        logic [ROOT_W-1:0]   s_den;
        logic [NORMAL_W-1:0] s_quo;
        logic [ROOT_W:0]     t_rem;
        logic [ROOT_W:0]     diff;

        if (k == 0) begin : g_first
            // upper numerator bits are already below the divisor
            assign s_rem = ROOT_W'(i_num[NUM_W-1:NORMAL_W]);
            assign s_low = i_num[NORMAL_W-1:0];
            assign s_den = i_den;
            assign s_quo = '0;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_low = r_low[k-1];
            assign s_den = r_den[k-1];
            assign s_quo = r_quo[k-1];
        end

        assign t_rem = {s_rem, s_low[NORMAL_W-1]};
        assign diff  = t_rem - {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (t_rem >= {1'b0, s_den}) begin
                    r_rem[k] <= diff[ROOT_W-1:0];
                    r_quo[k] <= {s_quo[NORMAL_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= t_rem[ROOT_W-1:0];
                    r_quo[k] <= {s_quo[NORMAL_W-2:0], 1'b0};
                end
                r_low[k] <= {s_low[NORMAL_W-2:0], 1'b0};
                r_den[k] <= s_den;
            end
        end
    end

    assign o_quo = r_quo[NORMAL_W-1];

endmodule

// File: hdl/triangle_unit_normal_top.sv
// stages from input transfer to result: 8 front stages, 32 square root stages,
// 1 numerator stage, 16 divider stages, 1 output stage
// throughput: one triangle per cycle; a stalled output freezes the whole pipeline
// reset: synchronous active low, clears the valid bits only
// triangle_unit_normal_top: unit face normal pipeline; uses tun_pkg, tun_isqrt, tun_div
module triangle_unit_normal_top import tun_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef struct packed {
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic                degen;
    } t_side;

    logic           en;
    logic [LAT-1:0] r_vld;

    logic signed [COORD_W-1:0] va [3];
    logic signed [COORD_W-1:0] vb [3];
    logic signed [COORD_W-1:0] vc [3];

    logic signed [EDGE_W-1:0]  r_e0  [3];
    logic signed [EDGE_W-1:0]  r_e1  [3];
    logic signed [PROD_W-1:0]  r_p   [6];
    logic signed [CROSS_W-1:0] r_n   [3];
    logic [MAG_W-1:0]          r_mag [3];
    logic [2:0]                r_neg4;
    logic [MAG_W-1:0]          r_mag5 [3];
    logic [2:0]                r_neg5;
    logic [POS_W-1:0]          r_pos;
    logic                      r_degen5;
    t_side                     r_side6;
    logic [SQ_W-1:0]           r_sq [3];
    t_side                     r_side7;
    logic [SUM_W-1:0]          r_sum;
    t_side                     r_side8;
    t_side                     r_dl  [ROOT_W];
    logic [ROOT_W-1:0]         root;
    logic [NUM_W-1:0]          r_num [3];
    logic [ROOT_W-1:0]         r_den;
    t_side                     r_side9;
    t_side                     r_dl2 [NORMAL_W];
    logic [NORMAL_W-1:0]       quo   [3];
    t_out                      r_out;

    logic [MAG_W-1:0] mag_or;
    logic [POS_W-1:0] n_pos;
    logic [MAG_W-1:0] shifted [3];
    logic [NORMAL_W-1:0] comp [3];

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign va[0] = i_data.a_x;
    assign va[1] = i_data.a_y;
    assign va[2] = i_data.a_z;
    assign vb[0] = i_data.b_x;
    assign vb[1] = i_data.b_y;
    assign vb[2] = i_data.b_z;
    assign vc[0] = i_data.c_x;
    assign vc[1] = i_data.c_y;
    assign vc[2] = i_data.c_z;

    // edges, products, cross product, magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e0[i] <= {vb[i][COORD_W-1], vb[i]} - {va[i][COORD_W-1], va[i]};
                r_e1[i] <= {vc[i][COORD_W-1], vc[i]} - {va[i][COORD_W-1], va[i]};
            end
            r_p[0] <= r_e0[1] * r_e1[2];
            r_p[1] <= r_e0[2] * r_e1[1];
            r_p[2] <= r_e0[2] * r_e1[0];
            r_p[3] <= r_e0[0] * r_e1[2];
            r_p[4] <= r_e0[0] * r_e1[1];
            r_p[5] <= r_e0[1] * r_e1[0];
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= {r_p[2*i][PROD_W-1], r_p[2*i]}
                        - {r_p[2*i+1][PROD_W-1], r_p[2*i+1]};
            end
            for (int i = 0; i < 3; i++) begin
                r_neg4[i] <= r_n[i][CROSS_W-1];
                r_mag[i]  <= r_n[i][CROSS_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
            end
        end
    end

    // leading one of the largest component
    always_comb begin
        mag_or = r_mag[0] | r_mag[1] | r_mag[2];
        n_pos  = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mag_or[b]) begin
                n_pos = POS_W'(b);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_pos > POS_W'(NORM_TOP)) begin
                shifted[i] = r_mag5[i] >> (r_pos - POS_W'(NORM_TOP));
            end else begin
                shifted[i] = r_mag5[i] << (POS_W'(NORM_TOP) - r_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag5   <= r_mag;
            r_neg5   <= r_neg4;
            r_pos    <= n_pos;
            r_degen5 <= (mag_or == '0);

            for (int i = 0; i < 3; i++) begin
                r_side6.m[i] <= shifted[i][M_W-1:0];
            end
            r_side6.neg   <= r_neg5;
            r_side6.degen <= r_degen5;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_side6.m[i] * r_side6.m[i];
            end
            r_side7 <= r_side6;

            r_sum   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_side8 <= r_side7;

            r_dl[0] <= r_side8;
            for (int k = 1; k < ROOT_W; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    tun_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sum),
        .o_root (root)
    );

    // rounded numerator m * 2^15 + floor(len / 2)
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= (NUM_W'(r_dl[ROOT_W-1].m[i]) << (NORMAL_W - 1))
                          + NUM_W'(root >> 1);
            end
            r_den   <= root;
            r_side9 <= r_dl[ROOT_W-1];

            r_dl2[0] <= r_side9;
            for (int k = 1; k < NORMAL_W; k++) begin
                r_dl2[k] <= r_dl2[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        tun_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[i]),
            .i_den (r_den),
            .o_quo (quo[i])
        );
    end

    // sign and saturation; quotient never exceeds one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dl2[NORMAL_W-1].neg[i]) begin
                comp[i] = -quo[i];
            end else if (quo[i][NORMAL_W-1]) begin
                comp[i] = {1'b0, {(NORMAL_W-1){1'b1}}};
            end else begin
                comp[i] = quo[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dl2[NORMAL_W-1].degen) begin
                r_out.norm_x     <= '0;
                r_out.norm_y     <= '0;
                r_out.norm_z     <= '0;
                r_out.degenerate <= 1'b1;
            end else begin
                r_out.norm_x     <= comp[0];
                r_out.norm_y     <= comp[1];
                r_out.norm_z     <= comp[2];
                r_out.degenerate <= 1'b0;
            end
        end
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.norm_x == '0 && o_data.norm_y == '0 && o_data.norm_z == '0)
        else $error("degenerate result with nonzero normal");

    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.degenerate |->
            o_data.norm_x != '0 || o_data.norm_y != '0 || o_data.norm_z != '0)
        else $error("regular triangle gave zero normal");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && i_valid |=> r_vld[0])
        else $error("input transfer lost at pipeline entry");

endmodule

// File: test/tb.sv
// tb: self-checking bench for triangle_unit_normal_top, random and directed triangles
// depends on tun_pkg and the rtl under hdl; predicts each unit normal in exact integers
`timescale 1ns / 1ps

module tb;
    import tun_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    triangle_unit_normal_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    localparam int LIMIT = 400000;

    t_in  pending_tris[$];
    t_out expected_normals[$];
    int   errors;
    int   cycles;
    bit   stim_done;
    int   send_gap;
    int   recv_gap;
    int   hold_left;
    int   recv_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_out face_normal(t_in t);
        logic signed [31:0]  e0 [3];
        logic signed [31:0]  e1 [3];
        logic signed [66:0]  n [3];
        logic [65:0]         mg [3];
        logic [63:0]         m [3];
        logic [63:0]         sum;
        logic [63:0]         len;
        logic [63:0]         q;
        logic [15:0]         comp [3];
        int                  top;
        t_out                r;
        top = -1;
        e0[0] = 32'(t.b_x) - 32'(t.a_x);
        e0[1] = 32'(t.b_y) - 32'(t.a_y);
        e0[2] = 32'(t.b_z) - 32'(t.a_z);
        e1[0] = 32'(t.c_x) - 32'(t.a_x);
        e1[1] = 32'(t.c_y) - 32'(t.a_y);
        e1[2] = 32'(t.c_z) - 32'(t.a_z);
        n[0] = 67'(e0[1]) * 67'(e1[2]) - 67'(e0[2]) * 67'(e1[1]);
        n[1] = 67'(e0[2]) * 67'(e1[0]) - 67'(e0[0]) * 67'(e1[2]);
        n[2] = 67'(e0[0]) * 67'(e1[1]) - 67'(e0[1]) * 67'(e1[0]);
        for (int i = 0; i < 3; i++) begin
            mg[i] = n[i] < 0 ? 66'(-n[i]) : 66'(n[i]);
            for (int p = 0; p < 66; p++) if (mg[i][p] && p > top) top = p;
        end
        if (top < 0) begin
            r = '0;
            r.degenerate = 1'b1;
            return r;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (top > NORM_TOP) m[i] = 64'(mg[i] >> (top - NORM_TOP));
            else m[i] = 64'(mg[i] << (NORM_TOP - top));
            sum = sum + m[i] * m[i];
        end
        len = isqrt(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << (NORMAL_W - 1)) + (len >> 1)) / len;
            if (n[i] < 0) begin
                if (q > 64'd32768) q = 64'd32768;
                comp[i] = 16'(-q);
            end else begin
                if (q > 64'd32767) q = 64'd32767;
                comp[i] = 16'(q);
            end
        end
        r.norm_x = comp[0];
        r.norm_y = comp[1];
        r.norm_z = comp[2];
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 600)) - 24'd300;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in make_tri(int k);
        t_in t;
        t = {9{24'd0}};
        case (k)
            0: ;
            1: t = {9{24'h7fffff}};
            2: begin
                t.b_x = 24'h7fffff; t.b_y = 24'h800000;
                t.c_x = 24'h800000; t.c_z = 24'h7fffff;
                t.a_y = 24'h7fffff; t.a_z = 24'h800000;
            end
            3: begin t.b_x = 24'd256; t.c_y = 24'd256; end
            4: begin t.b_x = 24'd256; t.c_y = -24'sd256; end
            5: begin t.b_y = 24'd256; t.c_z = 24'd256; end
            6: begin t.b_z = 24'd256; t.c_y = 24'd256; end
            7: begin t.b_z = 24'd256; t.c_x = 24'd256; end
            8: begin t.b_x = 24'd1; t.c_x = 24'd2; end
            9: begin t.b_x = 24'd1; t.c_y = 24'd1; end
            10: begin t.b_x = 24'd1; t.b_y = 24'd1; t.c_y = 24'd1; t.c_z = 24'd1; end
            11: begin
                t.a_x = 24'h800000; t.b_x = 24'h7fffff; t.c_y = 24'h7fffff;
                t.c_x = 24'h800000; t.b_z = 24'h800000;
            end
            12: begin
                t.a_x = 24'h800000; t.a_y = 24'h800000; t.a_z = 24'h800000;
                t.b_x = 24'h7fffff; t.b_y = 24'h7fffff; t.b_z = 24'h800000;
                t.c_x = 24'h7fffff; t.c_y = 24'h800000; t.c_z = 24'h7fffff;
            end
            13: begin
                t.a_x = 24'd5; t.b_x = 24'd5; t.c_x = 24'd5; t.b_y = 24'd9; t.c_z = 24'd3;
            end
            default: begin
                t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
                t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
                t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
                // collinear third vertex now and then
                if ($urandom_range(0, 15) == 0) begin
                    t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
                end
            end
        endcase
        return t;
    endfunction

    initial begin
        errors = 0;
        stim_done = 0;
        for (int k = 0; k < 14; k++) pending_tris.push_back(make_tri(k));
        for (int k = 0; k < 1440; k++) pending_tris.push_back(make_tri(100));
        stim_done = 1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && !o_stall) begin
            expected_normals.push_back(face_normal(i_data));
            if (pending_tris.size() > 0 && $urandom_range(0, 3) != 0) begin
                i_data <= pending_tris.pop_front();
            end else begin
                i_valid <= 1'b0;
                send_gap <= $urandom_range(0, 9);
            end
        end else if (!i_valid) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            else if (pending_tris.size() > 0) begin
                i_data <= pending_tris.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // monitor with random stall and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
            recv_count <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time,
                             o_data);
                    errors <= errors + 1;
                end else if (o_data !== expected_normals[0]) begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             expected_normals[0], o_data);
                    errors <= errors + 1;
                    void'(expected_normals.pop_front());
                end else begin
                    void'(expected_normals.pop_front());
                end
                recv_count <= recv_count + 1;
            end
            if (recv_count == 200 && hold_left == 0 && !i_stall) begin
                hold_left <= 300;
                i_stall <= 1'b1;
            end else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
            end else if (hold_left == 1) begin
                hold_left <= -1;
                i_stall <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall && $urandom_range(0, 2) == 0) begin
                recv_gap <= $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && pending_tris.size() == 0 && !i_valid
                 && expected_normals.size() == 0) && cycles < LIMIT) begin
            @(posedge i_clk);
            cycles = cycles + 1;
        end
        if (cycles >= LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            repeat (LAT + 10) @(posedge i_clk);
            if (errors == 0 && expected_normals.size() == 0) $display("tb: PASS");
            else $display("tb: FAIL");
            $finish;
        end
    end
endmodule
